// File: design/qsfmc_pkg.sv
// ----------------------------------------------------------------------------
// qsfmc_pkg
// Shared types, constants and arithmetic helpers of the quadrature encoder
// state-feedback motor controller.
// ----------------------------------------------------------------------------
package qsfmc_pkg;

  // Fixed-point layout of the 48-bit signals.
  localparam int SigFracBits = 24;
  localparam int PosShift    = 32 - SigFracBits;
  localparam int FricShift   = SigFracBits - 16;

  // Shared shift-add multiplier and restoring divider.
  localparam int MagWidth  = 49;
  localparam int CoefWidth = 32;
  localparam int ProdWidth = MagWidth + CoefWidth;
  localparam int DivWidth  = 68;
  localparam int MulSteps  = CoefWidth;
  localparam int DivSteps  = DivWidth;
  localparam int CntWidth  = $clog2(DivSteps);

  localparam logic [CoefWidth-1:0] UsPerSec = 32'd1000000;
  localparam logic signed [47:0]   SigMax   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0]   SigMin   = 48'sh8000_0000_0000;

  // Operation codes of an input item.
  localparam logic OpEncoder = 1'b0;
  localparam logic OpTick    = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] RegPositionGain  = 3'd0;
  localparam logic [2:0] RegVelocityGain  = 3'd1;
  localparam logic [2:0] RegBackEmfCoeff  = 3'd2;
  localparam logic [2:0] RegFrictionCoeff = 3'd3;
  localparam logic [2:0] RegOutputScale   = 3'd4;
  localparam logic [2:0] RegTargetPos     = 3'd5;
  localparam logic [2:0] RegDistPerPulse  = 3'd6;
  localparam logic [2:0] RegDriveLimit    = 3'd7;

  typedef struct packed {
    logic        operation;
    logic        phase_a;
    logic        phase_b;
    logic [23:0] elapsed_us;
  } qsfmc_in_t;

  typedef struct packed {
    logic               direction;
    logic [7:0]         duty;
    logic signed [47:0] position;
    logic signed [47:0] velocity;
  } qsfmc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMul,
    StDiv,
    StPost,
    StDone
  } qsfmc_state_e;

  typedef enum logic [2:0] {
    StepPos,
    StepVel,
    StepDiv,
    StepKx,
    StepKv,
    StepBemf,
    StepScale
  } qsfmc_step_e;

  // Encoder transition decode on {previous phases, new phases}: {up, down}.
  function automatic logic [1:0] qsfmc_enc_move(input logic [3:0] s);
    logic [1:0] move;
    unique case (s) inside
      4'd13, 4'd4, 4'd2, 4'd11: move = 2'b10;
      4'd14, 4'd7, 4'd1, 4'd8:  move = 2'b01;
      default:                  move = 2'b00;
    endcase
    return move;
  endfunction

  function automatic logic [MagWidth-1:0] qsfmc_mag49(input logic signed [MagWidth-1:0] v);
    logic [MagWidth-1:0] r;
    r = v[MagWidth-1] ? MagWidth'(-v) : MagWidth'(v);
    return r;
  endfunction

  function automatic logic [CoefWidth-1:0] qsfmc_mag32(input logic signed [CoefWidth-1:0] v);
    logic [CoefWidth-1:0] r;
    r = v[CoefWidth-1] ? CoefWidth'(-v) : CoefWidth'(v);
    return r;
  endfunction

  // Product magnitude with 16 fraction bits dropped, saturated and signed.
  function automatic logic signed [47:0] qsfmc_mulq_fin(input logic [ProdWidth-1:0] prod,
                                                        input logic neg);
    logic        sat;
    logic [47:0] m;
    logic [47:0] r;
    sat = |prod[ProdWidth-1:63];
    m   = sat ? 48'h8000_0000_0000 : prod[63:16];
    if (neg) begin
      r = 48'(-m);
    end else begin
      r = sat ? SigMax : m;
    end
    return signed'(r);
  endfunction

  function automatic logic signed [47:0] qsfmc_sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (!v[49] && (v[48] || v[47])) begin
      r = SigMax;
    end else if (v[49] && !(v[48] && v[47])) begin
      r = SigMin;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// File: design/quadrature_state_feedback_motor_ctrl.sv
// ----------------------------------------------------------------------------
// quadrature_state_feedback_motor_ctrl
// Quadrature encoder counter with a fixed-point state-feedback cart motor
// controller built around one shared shift-add multiplier and a divider.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   -------   ------------------------   ------------------------------------
//   in        in_valid_i / in_ready_o     in_item_i  (qsfmc_in_t)
//   out       out_valid_o / out_ready_i   out_item_o (qsfmc_out_t)
//   cfg       cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// An encoder item is taken in the idle state and gives no result item.
// A control tick runs six passes of the 32-step shift-add multiplier and one
// 68-step division; with zero elapsed time it runs five passes and no division.
// The input is not ready while a tick is worked on; the result waits in an
// output register, and a new item is taken while it waits.
// Reset clears all control state and loads the default coefficients.
//
module quadrature_state_feedback_motor_ctrl #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  qsfmc_pkg::qsfmc_in_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output qsfmc_pkg::qsfmc_out_t  out_item_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import qsfmc_pkg::*;

  // Configuration registers.
  logic signed [31:0] kx_q, kv_q, bemf_q, fric_q, scale_q, target_q;
  logic [19:0]        dpp_q;
  logic [7:0]         drive_limit_q;

  // Sequencer and encoder state.
  qsfmc_state_e state_q, state_d;
  qsfmc_step_e  step_q, step_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [1:0]             prev_ph_q, prev_ph_d;
  logic [COUNT_WIDTH-1:0] pulse_q, pulse_d;
  logic signed [47:0]     last_pos_q, last_pos_d;

  // Datapath registers.
  logic [23:0]          elapsed_q, elapsed_d;
  logic signed [47:0]   pos_q, pos_d;
  logic signed [47:0]   vel_q, vel_d;
  logic signed [47:0]   acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic                 dneg_q, dneg_d;
  logic [ProdWidth-1:0] prod_q, prod_d;
  logic [MagWidth-1:0]  mula_q, mula_d;
  logic [23:0]          rem_q, rem_d;
  logic [DivWidth-1:0]  quo_q, quo_d;
  qsfmc_out_t           out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic in_accept;
  logic out_free;

  // Operand selection for the multiplier.
  logic signed [MagWidth-1:0] cnt_ext, dx, ex, x0, vel_ext, acc_ext;
  logic [MagWidth-1:0]        op_a;
  logic [CoefWidth-1:0]       op_b;
  logic                       op_neg;

  // Shared unit results.
  logic [MagWidth:0]         mul_sum;
  logic [24:0]               div_try;
  logic                      div_ge;
  logic signed [47:0]        mul_res;
  logic [ProdWidth-1:0]      prod_sgn;
  logic signed [49:0]        fric_ext, sum50;
  logic signed [47:0]        lim48, u_clamp, u_mag;
  logic [1:0]                move;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_q          <= 32'sd18704179;
      kv_q          <= 32'sd2431386;
      bemf_q        <= 32'sd2357985;
      fric_q        <= -32'sd182845;
      scale_q       <= 32'sd627315;
      target_q      <= 32'sd4260;
      dpp_q         <= 20'd64430;
      drive_limit_q <= 8'd250;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPositionGain:  kx_q          <= cfg_data_i;
        RegVelocityGain:  kv_q          <= cfg_data_i;
        RegBackEmfCoeff:  bemf_q        <= cfg_data_i;
        RegFrictionCoeff: fric_q        <= cfg_data_i;
        RegOutputScale:   scale_q       <= cfg_data_i;
        RegTargetPos:     target_q      <= cfg_data_i;
        RegDistPerPulse:  dpp_q         <= cfg_data_i[19:0];
        RegDriveLimit:    drive_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_item_i.operation == OpTick) begin
          state_d = StLoad;
        end
      end
      StLoad: state_d = StMul;
      StMul: begin
        if (cnt_q == CntWidth'(MulSteps - 1)) begin
          state_d = StPost;
        end
      end
      StDiv: begin
        if (cnt_q == CntWidth'(DivSteps - 1)) begin
          state_d = StPost;
        end
      end
      StPost: begin
        if (step_q == StepVel) begin
          state_d = StDiv;
        end else if (step_q == StepScale) begin
          state_d = StDone;
        end else begin
          state_d = StLoad;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == StIdle);
  end

  // Operand selection: one magnitude, one coefficient and the product sign.
  always_comb begin
    cnt_ext = signed'({{(MagWidth - COUNT_WIDTH){pulse_q[COUNT_WIDTH-1]}}, pulse_q});
    dx      = {pos_q[47], pos_q} - {last_pos_q[47], last_pos_q};
    x0      = signed'({{(MagWidth - 32){target_q[31]}}, target_q}) <<< FricShift;
    ex      = {pos_q[47], pos_q} - x0;
    vel_ext = {vel_q[47], vel_q};
    acc_ext = {acc_q[47], acc_q};
    op_a    = '0;
    op_b    = '0;
    op_neg  = 1'b0;
    unique case (step_q)
      StepPos: begin
        op_a   = qsfmc_mag49(cnt_ext);
        op_b   = CoefWidth'(dpp_q);
        op_neg = cnt_ext[MagWidth-1];
      end
      StepVel: begin
        op_a   = qsfmc_mag49(dx);
        op_b   = UsPerSec;
        op_neg = dx[MagWidth-1];
      end
      StepKx: begin
        op_a   = qsfmc_mag49(ex);
        op_b   = qsfmc_mag32(kx_q);
        op_neg = ex[MagWidth-1] ^ kx_q[31];
      end
      StepKv: begin
        op_a   = qsfmc_mag49(vel_ext);
        op_b   = qsfmc_mag32(kv_q);
        op_neg = vel_q[47] ^ kv_q[31];
      end
      StepBemf: begin
        op_a   = qsfmc_mag49(vel_ext);
        op_b   = qsfmc_mag32(bemf_q);
        op_neg = vel_q[47] ^ bemf_q[31];
      end
      StepScale: begin
        op_a   = qsfmc_mag49(acc_ext);
        op_b   = qsfmc_mag32(scale_q);
        op_neg = acc_q[47] ^ scale_q[31];
      end
      default: ;
    endcase
  end

  // Shared arithmetic: one multiplier step, one divider step, post-processing.
  always_comb begin
    mul_sum  = {1'b0, prod_q[ProdWidth-1:CoefWidth]}
             + (prod_q[0] ? {1'b0, mula_q} : '0);
    div_try  = {rem_q, quo_q[DivWidth-1]};
    div_ge   = div_try >= {1'b0, elapsed_q};
    mul_res  = qsfmc_mulq_fin(prod_q, neg_q);
    prod_sgn = neg_q ? ProdWidth'(-prod_q) : prod_q;
    fric_ext = signed'({{18{fric_q[31]}}, fric_q}) <<< FricShift;
    lim48    = signed'(48'(drive_limit_q) << SigFracBits);
    u_clamp  = mul_res;
    if (mul_res > lim48) begin
      u_clamp = lim48;
    end else if (mul_res < -lim48) begin
      u_clamp = -lim48;
    end
    u_mag    = acc_q[47] ? -acc_q : acc_q;
    move     = qsfmc_enc_move({prev_ph_q, in_item_i.phase_a, in_item_i.phase_b});
    sum50    = '0;
    if (step_q == StepKv) begin
      sum50 = -({{2{acc_q[47]}}, acc_q} + {{2{mul_res[47]}}, mul_res});
    end else begin
      sum50 = {{2{acc_q[47]}}, acc_q} + {{2{mul_res[47]}}, mul_res};
      if (vel_q > 0) begin
        sum50 = sum50 - fric_ext;
      end else if (vel_q < 0) begin
        sum50 = sum50 + fric_ext;
      end
    end
  end

  // Datapath next values.
  always_comb begin
    step_d      = step_q;
    cnt_d       = cnt_q;
    prev_ph_d   = prev_ph_q;
    pulse_d     = pulse_q;
    last_pos_d  = last_pos_q;
    elapsed_d   = elapsed_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    dneg_d      = dneg_q;
    prod_d      = prod_q;
    mula_d      = mula_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (in_item_i.operation == OpEncoder) begin
            prev_ph_d = {in_item_i.phase_a, in_item_i.phase_b};
            if (move[1]) begin
              pulse_d = pulse_q + COUNT_WIDTH'(1);
            end else if (move[0]) begin
              pulse_d = pulse_q - COUNT_WIDTH'(1);
            end
          end else begin
            elapsed_d = in_item_i.elapsed_us;
            step_d    = StepPos;
          end
        end
      end
      StLoad: begin
        prod_d = {{MagWidth{1'b0}}, op_b};
        mula_d = op_a;
        neg_d  = op_neg;
        cnt_d  = '0;
        if (step_q == StepVel) begin
          dneg_d = op_neg;
        end
      end
      StMul: begin
        prod_d = {mul_sum, prod_q[CoefWidth-1:1]};
        cnt_d  = cnt_q + CntWidth'(1);
      end
      StDiv: begin
        rem_d = div_ge ? 24'(div_try - {1'b0, elapsed_q}) : div_try[23:0];
        quo_d = {quo_q[DivWidth-2:0], div_ge};
        cnt_d = cnt_q + CntWidth'(1);
      end
      StPost: begin
        unique case (step_q)
          StepPos: begin
            pos_d = prod_sgn[PosShift +: 48];
            if (elapsed_q == '0) begin
              vel_d  = '0;
              step_d = StepKx;
            end else begin
              step_d = StepVel;
            end
          end
          StepVel: begin
            rem_d  = '0;
            quo_d  = prod_q[DivWidth-1:0];
            cnt_d  = '0;
            step_d = StepDiv;
          end
          StepDiv: begin
            if (|quo_q[DivWidth-1:47]) begin
              vel_d = dneg_q ? SigMin : SigMax;
            end else begin
              vel_d = dneg_q ? -signed'(quo_q[47:0]) : signed'(quo_q[47:0]);
            end
            step_d = StepKx;
          end
          StepKx: begin
            acc_d  = mul_res;
            step_d = StepKv;
          end
          StepKv: begin
            acc_d  = qsfmc_sat48(sum50);
            step_d = StepBemf;
          end
          StepBemf: begin
            acc_d  = qsfmc_sat48(sum50);
            step_d = StepScale;
          end
          StepScale: begin
            acc_d = u_clamp;
          end
          default: ;
        endcase
      end
      StDone: begin
        if (out_free) begin
          out_d.direction = !(acc_q > 0);
          out_d.duty      = u_mag[SigFracBits +: 8];
          out_d.position  = pos_q;
          out_d.velocity  = vel_q;
          out_valid_d     = 1'b1;
          last_pos_d      = pos_q;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepPos;
      cnt_q       <= '0;
      prev_ph_q   <= '0;
      pulse_q     <= '0;
      last_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      prev_ph_q   <= prev_ph_d;
      pulse_q     <= pulse_d;
      last_pos_q  <= last_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    pos_q     <= pos_d;
    vel_q     <= vel_d;
    acc_q     <= acc_d;
    neg_q     <= neg_d;
    dneg_q    <= dneg_d;
    prod_q    <= prod_d;
    mula_q    <= mula_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An encoder item moves the count by at most one step.
  a_enc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.operation == OpEncoder |=>
      (pulse_q == $past(pulse_q)) ||
      (pulse_q == $past(pulse_q) + COUNT_WIDTH'(1)) ||
      (pulse_q == $past(pulse_q) - COUNT_WIDTH'(1)))
    else $error("encoder count moved by more than one");

  // A control tick blocks the input until its result is out.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.operation == OpTick |=> !in_ready_o)
    else $error("input ready while a tick is in progress");

  // The multiplier step counter stays within its pass.
  a_mul_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |-> cnt_q < CntWidth'(MulSteps))
    else $error("multiplier step counter out of range");

  // A finished result waits while the output slot is still full.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && out_valid_q && !out_ready_i |=> state_q == StDone)
    else $error("result left the sequencer into a full output slot");

endmodule

// File: bench/tb_quadrature_state_feedback_motor_ctrl.sv
// ----------------------------------------------------------------------------
// tb_quadrature_state_feedback_motor_ctrl
// Self-checking bench: directed and random encoder and tick items are checked against a
// behavioral model of the counter and control law, under idle and stall phases.
// ----------------------------------------------------------------------------
module tb_quadrature_state_feedback_motor_ctrl;
  import qsfmc_pkg::*;

  localparam longint CycleLimit = 2000000;
  localparam int     TickCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  qsfmc_in_t   in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  qsfmc_out_t  out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Idle percentages of the sender and the receiver; 0 means no idling.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int errors = 0;
  longint cycle_count = 0;

  // Model copy of the registers and the controller state.
  logic signed [31:0] kx, kv, bemf, fric, oscale, x0_reg;
  logic [19:0] dist_pulse;
  logic [7:0]  drv_limit;
  logic [1:0]  prev_phases;
  logic [31:0] pulse_count;
  logic [47:0] last_pos;

  qsfmc_out_t drive_queue[$];

  quadrature_state_feedback_motor_ctrl DUT (.*);

  always #1 clk_i = ~clk_i;

  // The run is stopped hard if it exceeds a generous cycle budget.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint sat_sig(input longint v);
    if (v > longint'(SigMax)) return longint'(SigMax);
    if (v < longint'(SigMin)) return longint'(SigMin);
    return v;
  endfunction

  // Signal times Q16.16 coefficient, truncated toward zero, saturated to 48 bits.
  function automatic longint coef_mul(input longint a, input longint c);
    logic [127:0] ma, mc, p;
    logic         neg;
    longint       lim;
    neg = (a < 0) != (c < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mc = (c < 0) ? 128'(-c) : 128'(c);
    p = (ma * mc) >> 16;
    lim = 64'sd1 <<< 47;
    if (p > 128'(lim)) p = 128'(lim);
    if (neg) return -longint'(p[63:0]);
    return (longint'(p[63:0]) == lim) ? longint'(SigMax) : longint'(p[63:0]);
  endfunction

  task automatic reset_model();
    kx = 32'sd18704179; kv = 32'sd2431386; bemf = 32'sd2357985;
    fric = -32'sd182845; oscale = 32'sd627315; x0_reg = 32'sd4260;
    dist_pulse = 20'd64430; drv_limit = 8'd250;
    prev_phases = '0; pulse_count = '0; last_pos = '0;
  endtask

  // Advances the model by one item; ticks push the expected drive result.
  task automatic model_step(input qsfmc_in_t it);
    logic [3:0]   s;
    longint       cnt, x, dx, v, ctl, tot, u, lim, sgn;
    logic [127:0] prod, m, q;
    qsfmc_out_t   r;
    if (it.operation == OpEncoder) begin
      s = {prev_phases, it.phase_a, it.phase_b};
      if (s inside {4'd13, 4'd4, 4'd2, 4'd11}) pulse_count = pulse_count + 1;
      else if (s inside {4'd14, 4'd7, 4'd1, 4'd8}) pulse_count = pulse_count - 1;
      prev_phases = {it.phase_a, it.phase_b};
      return;
    end
    cnt = longint'(signed'(pulse_count));
    prod = 128'(cnt * longint'({12'd0, dist_pulse}));
    r.position = prod[PosShift +: 48];
    x = longint'(r.position);
    v = 0;
    if (it.elapsed_us != 0) begin
      dx = x - longint'(signed'(last_pos));
      m = (dx < 0) ? 128'(-dx) : 128'(dx);
      q = (m * 1000000) / it.elapsed_us;
      lim = 64'sd1 <<< 47;
      if (q > 128'(lim)) q = 128'(lim);
      if (dx < 0) v = -longint'(q[63:0]);
      else v = (longint'(q[63:0]) == lim) ? longint'(SigMax) : longint'(q[63:0]);
    end
    sgn = (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    ctl = sat_sig(-(coef_mul(x - longint'(x0_reg) * 256, longint'(kx)) +
                    coef_mul(v, longint'(kv))));
    tot = sat_sig(ctl + coef_mul(v, longint'(bemf)) - longint'(fric) * 256 * sgn);
    u = coef_mul(tot, longint'(oscale));
    lim = longint'(drv_limit) <<< SigFracBits;
    if (u > lim) u = lim;
    else if (u < -lim) u = -lim;
    r.direction = (u > 0) ? 1'b0 : 1'b1;
    r.duty = 8'(((u < 0) ? -u : u) >>> SigFracBits);
    r.velocity = 48'(v);
    last_pos = r.position;
    drive_queue.push_back(r);
  endtask

  // Sends one item, with a random idle gap before it in idle phases. Valid
  // stays high on return; the next item, an idle gap or drain() follows at
  // the same falling edge.
  task automatic send_item(input qsfmc_in_t it);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_step(it);
    @(negedge clk_i);
  endtask

  // Waits for all results, then for the block to finish any work in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_queue.size() != 0) @(negedge clk_i);
    repeat (TickCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegPositionGain:  kx = val;
      RegVelocityGain:  kv = val;
      RegBackEmfCoeff:  bemf = val;
      RegFrictionCoeff: fric = val;
      RegOutputScale:   oscale = val;
      RegTargetPos:     x0_reg = val;
      RegDistPerPulse:  dist_pulse = val[19:0];
      default:          drv_limit = val[7:0];
    endcase
  endtask

  function automatic qsfmc_in_t make_item(input logic op, input logic [1:0] ph,
                                          input logic [23:0] us);
    qsfmc_in_t it;
    it.operation = op;
    {it.phase_a, it.phase_b} = ph;
    it.elapsed_us = us;
    return it;
  endfunction

  function automatic logic [23:0] rand_elapsed();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 20));
      3: return 24'($urandom);
      default: return 24'($urandom_range(2000, 10000));
    endcase
  endfunction

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_queue.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        automatic qsfmc_out_t e = drive_queue.pop_front();
        if (out_item_o.direction !== e.direction) begin
          $error("direction expected %0d got %0d", e.direction, out_item_o.direction);
          errors++;
        end
        if (out_item_o.duty !== e.duty) begin
          $error("duty expected %0d got %0d", e.duty, out_item_o.duty);
          errors++;
        end
        if (out_item_o.position !== e.position) begin
          $error("position expected %0d got %0d", e.position, out_item_o.position);
          errors++;
        end
        if (out_item_o.velocity !== e.velocity) begin
          $error("velocity expected %0d got %0d", e.velocity, out_item_o.velocity);
          errors++;
        end
      end
    end
  end

  // Receiver stalls are redrawn each falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
  end

  // Directed: every encoder transition, extreme elapsed times, ticks at rest.
  task automatic test_directed();
    for (int p = 0; p < 4; p++)
      for (int n = 0; n < 4; n++) begin
        send_item(make_item(OpEncoder, 2'(p), 24'($urandom)));
        send_item(make_item(OpEncoder, 2'(n), 24'($urandom)));
      end
    send_item(make_item(OpTick, 2'b11, 24'd0));
    send_item(make_item(OpTick, 2'b00, 24'd1));
    send_item(make_item(OpTick, 2'b10, 24'hFFFFFF));
    // A walk backward through the four phase states so the next tick sees a large step.
    for (int i = 0; i < 4; i++) send_item(make_item(OpEncoder, 2'(i ^ (i >> 1)), 24'd0));
    send_item(make_item(OpTick, 2'b01, 24'd1));
    drain();
  endtask

  // Random mix: phase walks of valid steps, repeated and skipped states, and ticks.
  task automatic test_random(input int n_items);
    int sent;
    int dir;
    logic [1:0] gray;
    sent = 0;
    while (sent < n_items) begin
      dir = $urandom_range(1);
      for (int k = $urandom_range(1, 30); k > 0 && sent < n_items; k--) begin
        gray = {prev_phases[1] ^ prev_phases[0], prev_phases[0]};
        gray = dir ? gray + 1 : gray - 1;
        gray = {gray[1], gray[1] ^ gray[0]};
        if ($urandom_range(9) == 0) gray = 2'($urandom);
        send_item(make_item(OpEncoder, gray, 24'($urandom)));
        sent++;
      end
      send_item(make_item(OpTick, 2'($urandom), rand_elapsed()));
      sent++;
    end
    drain();
  endtask

  // Register settings: extremes and random values.
  task automatic test_config(input int setting);
    logic [31:0] pick[4];
    pick[0] = 32'h8000_0000; pick[1] = 32'h7FFF_FFFF; pick[2] = 32'd0; pick[3] = $urandom;
    case (setting)
      0: for (int r = 0; r < 8; r++) write_reg(3'(r), pick[$urandom_range(3)]);
      1: begin
        write_reg(RegDistPerPulse, 32'hFFFFF);
        write_reg(RegDriveLimit, 32'd255);
        write_reg(RegOutputScale, 32'h7FFF_FFFF);
      end
      2: begin
        write_reg(RegDistPerPulse, 32'd0);
        write_reg(RegDriveLimit, 32'd0);
      end
      default: begin
        for (int r = 0; r < 6; r++) write_reg(3'(r), 32'($signed($urandom) >>> 8));
        write_reg(RegDistPerPulse, $urandom_range(1, 1048575));
        write_reg(RegDriveLimit, $urandom_range(255));
      end
    endcase
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
        default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
      endcase
      test_random(180);
      test_config(ph < 4 ? ph : 3 + (ph % 2) * ($urandom_range(2)));
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(RegPositionGain, 32'sd18704179);
    write_reg(RegDriveLimit, 32'd250);
    write_reg(RegDistPerPulse, 32'd64430);
    test_random(350);

    drain();
    if (errors == 0 && drive_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
